// ----- rtl/core/cmfs_pkg.sv -----
package cmfs_pkg;

    // Fixed widths of the face-local results
    localparam int COORD_W    = 17;
    localparam int FRAC_BITS  = 15;
    localparam int SIZE_W     = 13;
    localparam int TEXEL_W    = 12;
    localparam int OFFSET_W   = 24;
    localparam int FACE_W     = 3;

    // Divider layout: one stage for the integer part, then fraction bits in groups
    localparam int BITS_PER_STAGE = 3;
    localparam int DIV_STAGES     = 1 + FRAC_BITS / BITS_PER_STAGE;

    // Texel scaling widths
    localparam int PROD_W  = COORD_W + SIZE_W;
    localparam int SCALE_W = PROD_W - 16;

    typedef enum logic [FACE_W-1:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } t_face;

endpackage

// ----- rtl/core/cmfs_div.sv -----
module cmfs_div
    import cmfs_pkg::*;
#(
    parameter int DW = 16
) (
    input  logic                  i_clk,
    input  logic [DIV_STAGES-1:0] i_en,
    input  logic [DW:0]           i_num,
    input  logic [DW-1:0]         i_den,
    output logic [COORD_W-1:0]    o_quot
);

    logic [DW:0]        r_rem [DIV_STAGES];
    logic [DW-1:0]      r_den [DIV_STAGES];
    logic [COORD_W-1:0] r_q   [DIV_STAGES];

    logic [DW:0]        n_rem0;
    logic [COORD_W-1:0] n_q0;
    logic [DW:0]        twice_den;

    // Integer part: numerator lies in 0 to twice the divisor
    always_comb begin
        twice_den = {i_den, 1'b0};
        n_q0      = '0;
        if (i_num >= twice_den) begin
            n_q0[COORD_W-1:FRAC_BITS] = 2'd2;
            n_rem0                    = i_num - twice_den;
        end else if (i_num >= {1'b0, i_den}) begin
            n_q0[COORD_W-1:FRAC_BITS] = 2'd1;
            n_rem0                    = i_num - {1'b0, i_den};
        end else begin
            n_rem0 = i_num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= n_rem0;
            r_den[0] <= i_den;
            r_q[0]   <= n_q0;
        end
    end

    // Fraction bits: restoring long division, three bits per stage
    for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
        localparam int HI = FRAC_BITS - 1 - (k - 1) * BITS_PER_STAGE;

        logic [DW:0]        n_rem;
        logic [COORD_W-1:0] n_q;

        always_comb begin
            n_rem = r_rem[k-1];
            n_q   = r_q[k-1];
            for (int j = 0; j < BITS_PER_STAGE; j++) begin
                n_rem = {n_rem[DW-1:0], 1'b0};
                if (n_rem >= {1'b0, r_den[k-1]}) begin
                    n_rem      = n_rem - {1'b0, r_den[k-1]};
                    n_q[HI-j]  = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k] <= n_rem;
                r_den[k] <= r_den[k-1];
                r_q[k]   <= n_q;
            end
        end
    end

    assign o_quot = r_q[DIV_STAGES-1];

endmodule

// ----- rtl/core/cube_map_face_select.sv -----
// One word per cycle when the output is not stalled; eleven register stages (select, offset add, six
// divider stages, scale multiply, clamp, offset multiply) each move when free.
// Stalls at the output collapse bubbles upstream; nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and sets the face edge size to 16.
module cube_map_face_select
    import cmfs_pkg::*;
#(
    parameter int MAX_FACE_SIZE = 4096,
    parameter int DIR_BITS      = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [SIZE_W-1:0]          i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [DIR_BITS-1:0] i_dir_x,
    input  logic signed [DIR_BITS-1:0] i_dir_y,
    input  logic signed [DIR_BITS-1:0] i_dir_z,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [FACE_W-1:0]          o_face,
    output logic [COORD_W-1:0]         o_coord_u,
    output logic [COORD_W-1:0]         o_coord_v,
    output logic [TEXEL_W-1:0]         o_texel_col,
    output logic [TEXEL_W-1:0]         o_texel_row,
    output logic [OFFSET_W-1:0]        o_texel_offset,
    output logic                       o_zero_direction
);

    localparam int NSTAGE    = 2 + DIV_STAGES + 3;
    localparam int DIV0      = 2;
    localparam int ST_M1     = DIV0 + DIV_STAGES;
    localparam int ST_M2     = ST_M1 + 1;
    localparam int ST_M3     = ST_M2 + 1;
    localparam int SIZE_RST  = (MAX_FACE_SIZE < 16) ? MAX_FACE_SIZE : 16;
    localparam int OFF_W     = 2 * SIZE_W;

    // ---------------------------------------------------------------
    // Face size register, clamped on write
    // ---------------------------------------------------------------
    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W-1:0] n_size;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_size = SIZE_W'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_FACE_SIZE)) begin
            n_size = SIZE_W'(MAX_FACE_SIZE);
        end else begin
            n_size = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_W'(SIZE_RST);
        end else if (i_cfg_valid) begin
            r_size <= n_size;
        end
    end

    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // Stage valids and advance chain
    // ---------------------------------------------------------------
    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] adv;

    always_comb begin
        adv[NSTAGE-1] = ~r_vld[NSTAGE-1] | i_out_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            adv[k] = ~r_vld[k] | adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = adv[0];
    assign o_out_valid = r_vld[NSTAGE-1];

    // ---------------------------------------------------------------
    // Stage 1: major axis, face, signed minor components
    // ---------------------------------------------------------------
    logic signed [DIR_BITS:0] xs, ys, zs;
    logic signed [DIR_BITS:0] axw, ayw, azw;
    logic [DIR_BITS-1:0]      ax, ay, az;
    logic                     zero;
    t_face                    n_s1_face;
    logic [DIR_BITS-1:0]      n_s1_ma;
    logic signed [DIR_BITS:0] n_s1_sc, n_s1_tc;

    always_comb begin
        xs  = {i_dir_x[DIR_BITS-1], i_dir_x};
        ys  = {i_dir_y[DIR_BITS-1], i_dir_y};
        zs  = {i_dir_z[DIR_BITS-1], i_dir_z};
        axw = xs[DIR_BITS] ? -xs : xs;
        ayw = ys[DIR_BITS] ? -ys : ys;
        azw = zs[DIR_BITS] ? -zs : zs;
        ax  = axw[DIR_BITS-1:0];
        ay  = ayw[DIR_BITS-1:0];
        az  = azw[DIR_BITS-1:0];
        zero = (i_dir_x == '0) && (i_dir_y == '0) && (i_dir_z == '0);

        if (ax >= ay && ax >= az) begin
            n_s1_ma = ax;
            n_s1_tc = -ys;
            if (xs > 0) begin
                n_s1_face = FACE_POS_X;
                n_s1_sc   = -zs;
            end else begin
                n_s1_face = FACE_NEG_X;
                n_s1_sc   = zs;
            end
        end else if (ay >= ax && ay >= az) begin
            n_s1_ma = ay;
            n_s1_sc = xs;
            if (ys > 0) begin
                n_s1_face = FACE_POS_Y;
                n_s1_tc   = zs;
            end else begin
                n_s1_face = FACE_NEG_Y;
                n_s1_tc   = -zs;
            end
        end else begin
            n_s1_ma = az;
            n_s1_tc = -ys;
            if (zs > 0) begin
                n_s1_face = FACE_POS_Z;
                n_s1_sc   = xs;
            end else begin
                n_s1_face = FACE_NEG_Z;
                n_s1_sc   = -xs;
            end
        end

        // Zero vector: divide zero by one so every coordinate comes out zero
        if (zero) begin
            n_s1_face = FACE_NEG_X;
            n_s1_ma   = DIR_BITS'(1);
            n_s1_sc   = -(DIR_BITS+1)'(1);
            n_s1_tc   = -(DIR_BITS+1)'(1);
        end
    end

    t_face                    r_s1_face;
    logic                     r_s1_zero;
    logic [DIR_BITS-1:0]      r_s1_ma;
    logic signed [DIR_BITS:0] r_s1_sc, r_s1_tc;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s1_face <= n_s1_face;
            r_s1_zero <= zero;
            r_s1_ma   <= n_s1_ma;
            r_s1_sc   <= n_s1_sc;
            r_s1_tc   <= n_s1_tc;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: shift minor components into 0 to twice the major
    // ---------------------------------------------------------------
    logic signed [DIR_BITS:0] ma_s;
    logic [DIR_BITS:0]        n_s2_num_u, n_s2_num_v;

    always_comb begin
        ma_s       = $signed({1'b0, r_s1_ma});
        n_s2_num_u = (DIR_BITS+1)'(r_s1_sc + ma_s);
        n_s2_num_v = (DIR_BITS+1)'(r_s1_tc + ma_s);
    end

    t_face               r_s2_face;
    logic                r_s2_zero;
    logic [DIR_BITS-1:0] r_s2_ma;
    logic [DIR_BITS:0]   r_s2_num_u, r_s2_num_v;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s2_face  <= r_s1_face;
            r_s2_zero  <= r_s1_zero;
            r_s2_ma    <= r_s1_ma;
            r_s2_num_u <= n_s2_num_u;
            r_s2_num_v <= n_s2_num_v;
        end
    end

    // ---------------------------------------------------------------
    // Divider stages: coordinate = num * 2^15 / ma
    // ---------------------------------------------------------------
    logic [COORD_W-1:0] div_u, div_v;

    cmfs_div #(.DW(DIR_BITS)) u_div_u (
        .i_clk  (i_clk),
        .i_en   (adv[DIV0 +: DIV_STAGES]),
        .i_num  (r_s2_num_u),
        .i_den  (r_s2_ma),
        .o_quot (div_u)
    );

    cmfs_div #(.DW(DIR_BITS)) u_div_v (
        .i_clk  (i_clk),
        .i_en   (adv[DIV0 +: DIV_STAGES]),
        .i_num  (r_s2_num_v),
        .i_den  (r_s2_ma),
        .o_quot (div_v)
    );

    // Carry face and zero flag alongside the divider
    t_face r_side_face [DIV_STAGES];
    logic  r_side_zero [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (adv[DIV0]) begin
            r_side_face[0] <= r_s2_face;
            r_side_zero[0] <= r_s2_zero;
        end
        for (int k = 1; k < DIV_STAGES; k++) begin
            if (adv[DIV0+k]) begin
                r_side_face[k] <= r_side_face[k-1];
                r_side_zero[k] <= r_side_zero[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // M1: scale coordinates by face size
    // ---------------------------------------------------------------
    logic [PROD_W-1:0] prod_u, prod_v;

    assign prod_u = PROD_W'(div_u) * PROD_W'(r_size);
    assign prod_v = PROD_W'(div_v) * PROD_W'(r_size);

    t_face              r_m1_face;
    logic               r_m1_zero;
    logic [COORD_W-1:0] r_m1_u, r_m1_v;
    logic [SCALE_W-1:0] r_m1_tu, r_m1_tv;

    always_ff @(posedge i_clk) begin
        if (adv[ST_M1]) begin
            r_m1_face <= r_side_face[DIV_STAGES-1];
            r_m1_zero <= r_side_zero[DIV_STAGES-1];
            r_m1_u    <= div_u;
            r_m1_v    <= div_v;
            r_m1_tu   <= prod_u[PROD_W-1:16];
            r_m1_tv   <= prod_v[PROD_W-1:16];
        end
    end

    // ---------------------------------------------------------------
    // M2: clamp texel indices to size - 1
    // ---------------------------------------------------------------
    logic [SIZE_W-1:0] size_m1;
    logic [SIZE_W-1:0] n_m2_col, n_m2_row;

    always_comb begin
        size_m1  = r_size - SIZE_W'(1);
        n_m2_col = (r_m1_tu > SCALE_W'(size_m1)) ? size_m1 : r_m1_tu[SIZE_W-1:0];
        n_m2_row = (r_m1_tv > SCALE_W'(size_m1)) ? size_m1 : r_m1_tv[SIZE_W-1:0];
    end

    t_face              r_m2_face;
    logic               r_m2_zero;
    logic [COORD_W-1:0] r_m2_u, r_m2_v;
    logic [SIZE_W-1:0]  r_m2_col, r_m2_row;

    always_ff @(posedge i_clk) begin
        if (adv[ST_M2]) begin
            r_m2_face <= r_m1_face;
            r_m2_zero <= r_m1_zero;
            r_m2_u    <= r_m1_u;
            r_m2_v    <= r_m1_v;
            r_m2_col  <= n_m2_col;
            r_m2_row  <= n_m2_row;
        end
    end

    // ---------------------------------------------------------------
    // M3: linear offset and output register
    // ---------------------------------------------------------------
    logic [OFF_W-1:0] n_m3_off;

    assign n_m3_off = OFF_W'(r_m2_row) * OFF_W'(r_size) + OFF_W'(r_m2_col);

    t_face              r_m3_face;
    logic               r_m3_zero;
    logic [COORD_W-1:0] r_m3_u, r_m3_v;
    logic [SIZE_W-1:0]  r_m3_col, r_m3_row;
    logic [OFF_W-1:0]   r_m3_off;

    always_ff @(posedge i_clk) begin
        if (adv[ST_M3]) begin
            r_m3_face <= r_m2_face;
            r_m3_zero <= r_m2_zero;
            r_m3_u    <= r_m2_u;
            r_m3_v    <= r_m2_v;
            r_m3_col  <= r_m2_col;
            r_m3_row  <= r_m2_row;
            r_m3_off  <= n_m3_off;
        end
    end

    assign o_face           = r_m3_face;
    assign o_coord_u        = r_m3_u;
    assign o_coord_v        = r_m3_v;
    assign o_texel_col      = r_m3_col[TEXEL_W-1:0];
    assign o_texel_row      = r_m3_row[TEXEL_W-1:0];
    assign o_texel_offset   = r_m3_off[OFFSET_W-1:0];
    assign o_zero_direction = r_m3_zero;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_size_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size != '0)
        else $error("face size register holds zero");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted word missing from first stage");

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_direction) |->
            (o_face == FACE_NEG_X && o_coord_u == '0 && o_coord_v == '0
             && o_texel_offset == '0))
        else $error("zero direction gives nonzero result");

    a_coord_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_coord_u <= COORD_W'(65536) && o_coord_v <= COORD_W'(65536)))
        else $error("coordinate above one");

    a_texel_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_m3_col < r_size && r_m3_row < r_size))
        else $error("texel index not clamped to face size");

endmodule

// ----- tb/sv/cube_map_face_select_test.sv -----
module cube_map_face_select_test;
    import cmfs_pkg::*;

    localparam int DIR_W            = 16;
    localparam int MAX_SIZE         = 4096;
    localparam int RESET_CYCLES     = 11;
    localparam int RANDOM_PER_PHASE = 140;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES      = 40;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int REPORT_LIMIT     = 10;

    typedef struct packed {
        t_face                face;
        logic [COORD_W-1:0]   coord_u;
        logic [COORD_W-1:0]   coord_v;
        logic [TEXEL_W-1:0]   texel_col;
        logic [TEXEL_W-1:0]   texel_row;
        logic [OFFSET_W-1:0]  texel_offset;
        logic                 zero_direction;
    } t_texel_addr;

    typedef enum int {
        DRAIN_OPEN,
        DRAIN_LIGHT,
        DRAIN_HEAVY,
        DRAIN_PERIODIC
    } t_drain_mode;

    // Corner directions: zero vector, axis extremes, ties, most negative components
    localparam logic signed [DIR_W-1:0] CORNER_DIRS [23][3] = '{
        '{ 16'sd0,      16'sd0,      16'sd0      },
        '{ 16'sd32767,  16'sd0,      16'sd0      },
        '{ 16'sh8000,   16'sd0,      16'sd0      },
        '{ 16'sd0,      16'sd32767,  16'sd0      },
        '{ 16'sd0,      16'sh8000,   16'sd0      },
        '{ 16'sd0,      16'sd0,      16'sd32767  },
        '{ 16'sd0,      16'sd0,      16'sh8000   },
        '{ 16'sd5,      16'sd5,      16'sd5      },
        '{ 16'sd5,      -16'sd5,     -16'sd5     },
        '{ -16'sd5,     16'sd5,      -16'sd5     },
        '{ 16'sd0,      16'sd7,      16'sd7      },
        '{ 16'sd0,      -16'sd7,     -16'sd7     },
        '{ 16'sd3,      -16'sd7,     16'sd7      },
        '{ 16'sd1,      16'sd0,      -16'sd2     },
        '{ -16'sd1,     16'sd1,      16'sd2      },
        '{ 16'sh8000,   16'sh8000,   16'sh8000   },
        '{ 16'sd32767,  16'sh8000,   16'sd0      },
        '{ 16'sh8000,   16'sd32767,  16'sd32767  },
        '{ 16'sd0,      16'sd0,      -16'sd1     },
        '{ 16'sd1,      16'sd0,      16'sd0      },
        '{ 16'sd0,      -16'sd1,     16'sd0      },
        '{ 16'sd12345,  -16'sd20000, 16'sd30000  },
        '{ -16'sd32767, 16'sh8000,   16'sd100    }
    };

    // Face sizes visited after the reset value, extremes and out-of-range values included
    localparam logic [SIZE_W-1:0] SIZE_PLAN [8] = '{
        13'd1, 13'd4096, 13'd0, 13'd8191, 13'd4097, 13'd640, 13'd3, 13'd16
    };

    // Predict texel addresses and hold them until the block returns them
    class texel_scoreboard;
        logic [SIZE_W-1:0] edge_texels = 13'd16;
        t_texel_addr       expected_addrs[$];
        int                error_count = 0;

        function void set_edge_texels(logic [SIZE_W-1:0] value);
            edge_texels = value;
        endfunction

        function int pending();
            return expected_addrs.size();
        endfunction

        function t_texel_addr predict_texel_address(logic signed [DIR_W-1:0] x,
                                                    logic signed [DIR_W-1:0] y,
                                                    logic signed [DIR_W-1:0] z);
            longint      sx, sy, sz, ax, ay, az, major, s_minor, t_minor;
            longint      size, u, v, col, row;
            t_texel_addr r;
            sx = x;
            sy = y;
            sz = z;
            ax = (sx < 0) ? -sx : sx;
            ay = (sy < 0) ? -sy : sy;
            az = (sz < 0) ? -sz : sz;

            // Pick the major axis; ties go to X, then Y
            if (ax >= ay && ax >= az) begin
                major = ax;
                if (sx > 0) begin
                    r.face = FACE_POS_X; s_minor = -sz; t_minor = -sy;
                end else begin
                    r.face = FACE_NEG_X; s_minor = sz;  t_minor = -sy;
                end
            end else if (ay >= az) begin
                major = ay;
                if (sy > 0) begin
                    r.face = FACE_POS_Y; s_minor = sx; t_minor = sz;
                end else begin
                    r.face = FACE_NEG_Y; s_minor = sx; t_minor = -sz;
                end
            end else begin
                major = az;
                if (sz > 0) begin
                    r.face = FACE_POS_Z; s_minor = sx;  t_minor = -sy;
                end else begin
                    r.face = FACE_NEG_Z; s_minor = -sx; t_minor = -sy;
                end
            end

            // Clamp the register into 1..MAX_SIZE
            size = edge_texels;
            if (size == 0)
                size = 1;
            if (size > MAX_SIZE)
                size = MAX_SIZE;

            r.zero_direction = (sx == 0 && sy == 0 && sz == 0);
            if (r.zero_direction) begin
                r.face = FACE_NEG_X;
                u = 0; v = 0; col = 0; row = 0;
            end else begin
                u = ((s_minor + major) * 32768) / major;
                v = ((t_minor + major) * 32768) / major;
                col = (u * size) >>> 16;
                row = (v * size) >>> 16;
                if (col > size - 1)
                    col = size - 1;
                if (row > size - 1)
                    row = size - 1;
            end
            r.coord_u      = u[COORD_W-1:0];
            r.coord_v      = v[COORD_W-1:0];
            r.texel_col    = col[TEXEL_W-1:0];
            r.texel_row    = row[TEXEL_W-1:0];
            size           = row * size + col;
            r.texel_offset = size[OFFSET_W-1:0];
            return r;
        endfunction

        function void note_direction(logic signed [DIR_W-1:0] x,
                                     logic signed [DIR_W-1:0] y,
                                     logic signed [DIR_W-1:0] z);
            expected_addrs.push_back(predict_texel_address(x, y, z));
        endfunction

        function void report(string what, t_texel_addr want, t_texel_addr got);
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
                $display("%s: want face %0d u %0d v %0d col %0d row %0d off %0d zero %0b",
                         what, want.face, want.coord_u, want.coord_v, want.texel_col,
                         want.texel_row, want.texel_offset, want.zero_direction);
                $display("%s: got  face %0d u %0d v %0d col %0d row %0d off %0d zero %0b",
                         what, got.face, got.coord_u, got.coord_v, got.texel_col,
                         got.texel_row, got.texel_offset, got.zero_direction);
            end
        endfunction

        function void check_result(t_texel_addr got);
            t_texel_addr want;
            if (expected_addrs.size() == 0) begin
                report("unexpected word", '0, got);
                return;
            end
            want = expected_addrs.pop_front();
            if (got.face !== want.face || got.coord_u !== want.coord_u
                    || got.coord_v !== want.coord_v || got.texel_col !== want.texel_col
                    || got.texel_row !== want.texel_row
                    || got.texel_offset !== want.texel_offset
                    || got.zero_direction !== want.zero_direction)
                report("mismatch", want, got);
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic [SIZE_W-1:0]        cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic signed [DIR_W-1:0]  dir_x = '0;
    logic signed [DIR_W-1:0]  dir_y = '0;
    logic signed [DIR_W-1:0]  dir_z = '0;
    logic                     out_ready = 1'b0;
    int                       hold_ticket = 0;
    int                       cycle_count = 0;

    logic                     o_cfg_ready;
    logic                     o_in_ready;
    logic                     o_out_valid;
    logic [FACE_W-1:0]        o_face;
    logic [COORD_W-1:0]       o_coord_u;
    logic [COORD_W-1:0]       o_coord_v;
    logic [TEXEL_W-1:0]       o_texel_col;
    logic [TEXEL_W-1:0]       o_texel_row;
    logic [OFFSET_W-1:0]      o_texel_offset;
    logic                     o_zero_direction;

    texel_scoreboard sb = new;

    cube_map_face_select #(
        .MAX_FACE_SIZE (MAX_SIZE),
        .DIR_BITS      (DIR_W)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_dir_x          (dir_x),
        .i_dir_y          (dir_y),
        .i_dir_z          (dir_z),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_face           (o_face),
        .o_coord_u        (o_coord_u),
        .o_coord_v        (o_coord_v),
        .o_texel_col      (o_texel_col),
        .o_texel_row      (o_texel_row),
        .o_texel_offset   (o_texel_offset),
        .o_zero_direction (o_zero_direction)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("cube_map_face_select_test: FAIL");
            $finish;
        end
    end

    // Random component, biased toward the extremes, zero and small values
    function automatic logic signed [DIR_W-1:0] pick_component();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            3, 4:    return DIR_W'(int'($urandom_range(0, 64)) - 32);
            default: return DIR_W'($urandom());
        endcase
    endfunction

    // Random direction with a share of axis ties and tiny vectors
    function automatic void pick_direction(output logic signed [DIR_W-1:0] x,
                                           output logic signed [DIR_W-1:0] y,
                                           output logic signed [DIR_W-1:0] z);
        x = pick_component();
        y = pick_component();
        z = pick_component();
        case ($urandom_range(0, 7))
            0: y = $urandom_range(0, 1) ? x : -x;
            1: z = $urandom_range(0, 1) ? y : -y;
            2: begin
                y = $urandom_range(0, 1) ? x : -x;
                z = $urandom_range(0, 1) ? x : -x;
            end
            3: begin
                x = DIR_W'(int'($urandom_range(0, 4)) - 2);
                y = DIR_W'(int'($urandom_range(0, 4)) - 2);
                z = DIR_W'(int'($urandom_range(0, 4)) - 2);
            end
            default: ;
        endcase
    endfunction

    // Offer one direction word and hold it until accepted
    task automatic send_direction(input logic signed [DIR_W-1:0] x,
                                  input logic signed [DIR_W-1:0] y,
                                  input logic signed [DIR_W-1:0] z);
        in_valid <= 1'b1;
        dir_x    <= x;
        dir_y    <= y;
        dir_z    <= z;
        @(posedge clk);
        while (!o_in_ready)
            @(posedge clk);
        sb.note_direction(x, y, z);
    endtask

    // Send random directions in bursts, most of them followed by a random gap
    task automatic run_random(input int count);
        logic signed [DIR_W-1:0] x, y, z;
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && sent < count; i++) begin
                pick_direction(x, y, z);
                send_direction(x, y, z);
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    // Drain the pipeline, then write the face size word
    task automatic write_edge_texels(input logic [SIZE_W-1:0] value);
        while (sb.pending() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!o_cfg_ready)
            @(posedge clk);
        sb.set_edge_texels(value);
        cfg_valid <= 1'b0;
    endtask

    // Stall the output on a changing pattern, with a long hold-off on request
    initial begin : drain_stall
        t_drain_mode mode;
        int          mode_left;
        int          hold_left;
        int          hold_seen;
        int          tick;
        mode      = DRAIN_OPEN;
        mode_left = 0;
        hold_left = 0;
        hold_seen = 0;
        tick      = 0;
        forever begin
            @(posedge clk);
            tick++;
            if (mode_left == 0) begin
                mode      = t_drain_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (hold_ticket != hold_seen) begin
                hold_seen = hold_ticket;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case (mode)
                    DRAIN_OPEN:     out_ready <= 1'b1;
                    DRAIN_LIGHT:    out_ready <= ($urandom_range(0, 3) != 0);
                    DRAIN_HEAVY:    out_ready <= ($urandom_range(0, 3) == 0);
                    DRAIN_PERIODIC: out_ready <= (tick % 3 != 0);
                    default:        out_ready <= 1'b1;
                endcase
            end
        end
    end

    // Check every accepted output word
    initial begin : result_monitor
        t_texel_addr got;
        forever begin
            @(posedge clk);
            if (rst_n && o_out_valid && out_ready) begin
                got.face           = t_face'(o_face);
                got.coord_u        = o_coord_u;
                got.coord_v        = o_coord_v;
                got.texel_col      = o_texel_col;
                got.texel_row      = o_texel_row;
                got.texel_offset   = o_texel_offset;
                got.zero_direction = o_zero_direction;
                sb.check_result(got);
            end
        end
    end

    initial begin : stimulus
        int failures;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner directions at the reset face size
        foreach (CORNER_DIRS[i])
            send_direction(CORNER_DIRS[i][0], CORNER_DIRS[i][1], CORNER_DIRS[i][2]);
        run_random(RANDOM_PER_PHASE);

        // Walk the face size plan; hold off the output during one phase
        foreach (SIZE_PLAN[p]) begin
            write_edge_texels(SIZE_PLAN[p]);
            if (p == 1)
                hold_ticket <= hold_ticket + 1;
            run_random(RANDOM_PER_PHASE);
        end

        write_edge_texels(SIZE_W'($urandom_range(2, 4095)));
        hold_ticket <= hold_ticket + 1;
        run_random(RANDOM_PER_PHASE);

        // Wait for the last words, then watch for strays
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        failures = sb.error_count + sb.pending();
        if (failures == 0)
            $display("cube_map_face_select_test: PASS");
        else
            $display("cube_map_face_select_test: FAIL");
        $finish;
    end

endmodule
